// ===== rtl/hamming_secded_codec_defines.svh =====
// ----------------------------------------------------------------------------
// Hamming SECDED codec assertion macros
// Shared property shorthands for the codec's port checker.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SECDED_CODEC_DEFINES_SVH
`define HAMMING_SECDED_CODEC_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hamming_secded_codec port check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hamming_secded_codec port check failed");

`endif

// ===== rtl/hsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, constants and position tables for the Hamming SECDED codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int unsigned MaxDataBits = 26;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned ChkWidth    = 5;

  typedef enum logic [1:0] {
    ActEncode      = 2'd0,
    ActDecode      = 2'd1,
    ActCorrect     = 2'd2,
    ActSecdedCheck = 2'd3
  } hsc_action_e;

  typedef enum logic {
    CfgDataBits  = 1'b0,
    CfgSecdedEn  = 1'b1
  } hsc_cfg_idx_e;

  typedef struct packed {
    hsc_action_e           action;
    logic [WordWidth-1:0]  word_in;
  } hsc_in_t;

  typedef struct packed {
    logic [WordWidth-1:0] word_out;
    logic                 ok;
    logic [ChkWidth-1:0]  check_bits;
    logic [2:0]           check_count;
    logic                 overall_parity;
  } hsc_out_t;

  // Effective configuration as seen by the datapath.
  typedef struct packed {
    logic [4:0] data_width;
    logic [2:0] check_total;
    logic [4:0] code_bits;
    logic       secded_en;
  } hsc_cfg_t;

  // Bit index of each data bit inside the codeword (non power-of-two positions).
  localparam logic [4:0] DataBit [MaxDataBits] = '{
    5'd2,  5'd4,  5'd5,  5'd6,
    5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
    5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
    5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd30
  };

  // Bit index of each check bit (positions 1, 2, 4, 8, 16).
  localparam logic [4:0] ChkBit [ChkWidth] = '{5'd0, 5'd1, 5'd3, 5'd7, 5'd15};

  localparam logic [WordWidth-1:0] ChkMask = 32'h0000_808B;

  // Data positions covered by check bit k.
  function automatic logic [WordWidth-1:0] cover_mask(int unsigned k);
    logic [WordWidth-1:0] m;
    int unsigned pos;
    m = '0;
    for (pos = 1; pos < WordWidth; pos++) begin
      if (((pos >> k) & 1) != 0 && (pos & (pos - 1)) != 0) begin
        m[pos-1] = 1'b1;
      end
    end
    return m;
  endfunction

  localparam logic [WordWidth-1:0] CoverMask [ChkWidth] = '{
    cover_mask(0), cover_mask(1), cover_mask(2), cover_mask(3), cover_mask(4)
  };

endpackage

// ===== rtl/hsc_cfg.sv =====
// ----------------------------------------------------------------------------
// hsc_cfg
// Configuration registers and the derived code geometry.
// ----------------------------------------------------------------------------
module hsc_cfg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  hsc_pkg::hsc_cfg_idx_e cfg_idx_i,
  input  logic [4:0]            cfg_wdata_i,
  output hsc_pkg::hsc_cfg_t     cfg_o
);
  import hsc_pkg::*;

  logic [4:0] width_q;
  logic       secded_q;
  logic [4:0] data_eff;
  logic [2:0] chk_total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 5'd4;
      secded_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDataBits: width_q  <= cfg_wdata_i;
        CfgSecdedEn: secded_q <= cfg_wdata_i[0];
        default:     width_q  <= width_q;
      endcase
    end
  end

  // Out-of-range widths are clamped to the supported span.
  always_comb begin
    if (width_q == 5'd0) begin
      data_eff = 5'd1;
    end else if (width_q > 5'(MaxDataBits)) begin
      data_eff = 5'(MaxDataBits);
    end else begin
      data_eff = width_q;
    end
    if (data_eff == 5'd1) begin
      chk_total = 3'd2;
    end else if (data_eff <= 5'd4) begin
      chk_total = 3'd3;
    end else if (data_eff <= 5'd11) begin
      chk_total = 3'd4;
    end else begin
      chk_total = 3'd5;
    end
  end

  assign cfg_o.data_width  = data_eff;
  assign cfg_o.check_total = chk_total;
  assign cfg_o.code_bits   = data_eff + 5'(chk_total);
  assign cfg_o.secded_en   = secded_q;

endmodule

// ===== rtl/hsc_datapath.sv =====
// ----------------------------------------------------------------------------
// hsc_datapath
// Combinational encode, decode, correct and parity check for one item.
// ----------------------------------------------------------------------------
module hsc_datapath (
  input  hsc_pkg::hsc_cfg_t cfg_i,
  input  hsc_pkg::hsc_in_t  item_i,
  output hsc_pkg::hsc_out_t result_o
);
  import hsc_pkg::*;

  function automatic logic [ChkWidth-1:0] calc_checks(logic [WordWidth-1:0] wm);
    logic [ChkWidth-1:0] c;
    for (int k = 0; k < ChkWidth; k++) begin
      c[k] = ^(wm & CoverMask[k]);
    end
    return c;
  endfunction

  logic [WordWidth-1:0] word;
  logic [WordWidth-1:0] low_mask;
  logic [WordWidth-1:0] spread;
  logic [WordWidth-1:0] gathered;
  logic [WordWidth-1:0] enc_code;
  logic [ChkWidth-1:0]  enc_chk;
  logic                 enc_par;
  logic [ChkWidth-1:0]  rx_chk;
  logic [ChkWidth-1:0]  rx_recv;
  logic [ChkWidth-1:0]  syn;
  logic                 rx_par;
  logic [WordWidth-1:0] flip_mask;

  assign word     = item_i.word_in;
  assign low_mask = (32'd1 << cfg_i.code_bits) - 32'd1;

  // Data bits move between their packed order and the codeword positions.
  always_comb begin
    spread   = '0;
    gathered = '0;
    for (int j = 0; j < MaxDataBits; j++) begin
      if (5'(j) < cfg_i.data_width) begin
        spread[DataBit[j]] = word[j];
        gathered[j]        = word[DataBit[j]];
      end
    end
  end

  always_comb begin
    enc_chk  = calc_checks(spread);
    enc_code = spread;
    for (int k = 0; k < ChkWidth; k++) begin
      enc_code[ChkBit[k]] = enc_chk[k];
    end
    enc_par = ^enc_code;
    if (cfg_i.secded_en) begin
      enc_code[cfg_i.code_bits] = enc_par;
    end
  end

  always_comb begin
    rx_chk = calc_checks(word & low_mask & ~ChkMask);
    for (int k = 0; k < ChkWidth; k++) begin
      rx_recv[k] = word[ChkBit[k]] & (3'(k) < cfg_i.check_total);
    end
    syn       = rx_chk ^ rx_recv;
    rx_par    = ^(word & low_mask);
    flip_mask = 32'd1 << (syn - 5'd1);
  end

  always_comb begin
    result_o.word_out       = word;
    result_o.ok             = 1'b1;
    result_o.check_bits     = rx_chk;
    result_o.check_count    = cfg_i.check_total + 3'(cfg_i.secded_en);
    result_o.overall_parity = rx_par;
    case (item_i.action)
      ActEncode: begin
        result_o.word_out       = enc_code;
        result_o.check_bits     = enc_chk;
        result_o.overall_parity = enc_par;
      end
      ActDecode: begin
        result_o.word_out = gathered;
        result_o.ok       = (syn == '0);
      end
      ActCorrect: begin
        if (syn != '0) begin
          if (syn <= cfg_i.code_bits) begin
            result_o.word_out = word ^ flip_mask;
          end else begin
            result_o.ok = 1'b0;
          end
        end
      end
      ActSecdedCheck: begin
        result_o.ok = (rx_par == word[cfg_i.code_bits]);
      end
      default: begin
        result_o.ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/hamming_secded_codec.sv =====
// ----------------------------------------------------------------------------
// hamming_secded_codec
// Hamming single-error-correcting codec with optional SECDED overall parity.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                               Direction  Transfer when
//   -------   ------------------------------------  ---------  ----------------
//   command   start_i, item_i, busy_o               in         start_i & !busy_o
//   result    result_valid_o, result_o              out        result_valid_o
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i      in         cfg_we_i
//
// An item is first held in the input register, then the XOR trees of the
// datapath settle into the result register. A new command can be taken
// every cycle, so busy_o stays low. Each result is shown for exactly one
// cycle and the receiver cannot stall it. Reset clears the configuration
// to four data bits with SECDED off and empties both pipeline stages.
//
module hamming_secded_codec (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  hsc_pkg::hsc_in_t      item_i,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output hsc_pkg::hsc_out_t     result_o,
  input  logic                  cfg_we_i,
  input  hsc_pkg::hsc_cfg_idx_e cfg_idx_i,
  input  logic [4:0]            cfg_wdata_i
);
  import hsc_pkg::*;

  hsc_cfg_t cfg;
  hsc_in_t  item_q;
  logic     in_valid_q;
  hsc_out_t result_d;
  hsc_out_t result_q;
  logic     out_valid_q;
  logic     accept;

  // The pipeline never fills up, so a command is always welcome.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Configuration registers; the datapath sees the clamped width and the
  // derived check bit count and codeword length.
  hsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input stage. The payload holds no reset; only the valid flag does.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  // All the coding work happens in one pass of combinational logic.
  hsc_datapath u_datapath (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .result_o (result_d)
  );

  // Result stage. Each transfer is shown for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = result_q;

endmodule

// ===== rtl/hsc_checker.sv =====
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level checks of the codec's latency, strobe and result fields.
// ----------------------------------------------------------------------------
`include "hamming_secded_codec_defines.svh"

module hsc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input hsc_pkg::hsc_in_t  item_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input hsc_pkg::hsc_out_t result_o
);
  import hsc_pkg::*;

  logic cmd_xfer;
  assign cmd_xfer = start_i & ~busy_o;

  // Every command transfer yields a result after the input and result registers.
  `HSC_ASSERT_NOW(a_result_follows_cmd, cmd_xfer, ##2 result_valid_o)

  // No result appears without an earlier command transfer to match it.
  `HSC_ASSERT_NOW(a_no_spurious_result, result_valid_o, $past(cmd_xfer, 2))

  // An encode always reports success.
  `HSC_ASSERT_NOW(a_encode_ok,
                  result_valid_o && $past(item_i.action, 2) == ActEncode,
                  result_o.ok)

  // The check count covers two to five check bits plus the optional parity bit.
  `HSC_ASSERT_NOW(a_check_count_range, result_valid_o,
                  result_o.check_count >= 3'd2 && result_o.check_count <= 3'd6)

endmodule

bind hamming_secded_codec hsc_checker u_hsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .item_i         (item_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the Hamming SECDED codec. Commands are sent
// through the start/busy handshake with random gaps. Every accepted command
// is predicted by a behavioral model of the codec, and each result strobe
// is compared field by field, in order, against those predictions.
// ----------------------------------------------------------------------------
module tb_top;
  import hsc_pkg::*;

  // A stall this long with no transfer on any port means the codec is hung.
  localparam int unsigned StallLimit = 500;
  // Random commands per configuration setting in the random part.
  localparam int unsigned ItemsPerSetting = 88;
  localparam int unsigned RandomSettings = 16;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  hsc_in_t  item_i;
  logic     busy_o;
  logic     result_valid_o;
  hsc_out_t result_o;
  logic     cfg_we_i;
  hsc_cfg_idx_e cfg_idx_i;
  logic [4:0]   cfg_wdata_i;

  // Our own copy of the codec configuration, updated as the registers are
  // written. Reset brings the codec up with four data bits and SECDED off.
  logic [4:0] cfg_width = 5'd4;
  logic       cfg_secded = 1'b0;

  // Predicted results, oldest first, one per accepted command.
  hsc_out_t codec_results_due[$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  // Percentage of commands that are preceded by an idle gap.
  int unsigned idle_percent = 30;

  // Fixed settings visited first in the random part, {secded, width}.
  // They cover the clamped widths, the narrowest and widest codewords, and
  // a width whose syndrome can point past the end of the codeword.
  logic [5:0] fixed_settings [8] = '{
    {1'b0, 5'd1},  {1'b1, 5'd1},  {1'b0, 5'd26}, {1'b1, 5'd26},
    {1'b1, 5'd0},  {1'b0, 5'd31}, {1'b1, 5'd2},  {1'b0, 5'd11}
  };

  hamming_secded_codec i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 4 ns clock period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Behavioral model of the codec
  // ---------------------------------------------------------------------------

  // Positions 1, 2, 4, 8 and 16 carry check bits; all others carry data.
  function automatic bit is_check_pos(int unsigned pos);
    return (pos & (pos - 1)) == 0;
  endfunction

  // Data width actually used: out-of-range register values are clamped.
  function automatic int unsigned eff_width();
    int unsigned d;
    d = cfg_width;
    if (d < 1) d = 1;
    if (d > MaxDataBits) d = MaxDataBits;
    return d;
  endfunction

  // Smallest p with 2^p >= d + p + 1.
  function automatic int unsigned check_bit_count(int unsigned d);
    int unsigned p;
    p = 1;
    while ((1 << p) < d + p + 1) p++;
    return p;
  endfunction

  function automatic hsc_out_t predict_codec(hsc_action_e act, logic [31:0] w);
    hsc_out_t    r;
    int unsigned d, p, n, i, j;
    logic [31:0] code, low;
    logic [4:0]  calc, stored, syn;
    d = eff_width();
    p = check_bit_count(d);
    n = d + p;
    low = 32'((64'd1 << n) - 64'd1);
    code = '0;
    calc = '0;
    stored = '0;

    // On encode the data is first spread over the data positions; on the
    // other actions the received word is already in codeword layout.
    if (act == ActEncode) begin
      j = 0;
      for (i = 1; i <= n; i++) begin
        if (!is_check_pos(i)) begin
          code[i-1] = w[j];
          j++;
        end
      end
    end else begin
      code = w;
    end

    // Check bit k is the parity of the data positions with bit k set, which
    // is the same as XOR-ing together the indexes of all set data positions.
    for (i = 1; i <= n; i++) begin
      if (!is_check_pos(i) && code[i-1]) calc ^= 5'(i);
    end
    for (i = 0; i < p; i++) stored[i] = code[(1 << i) - 1];

    r.check_bits  = calc;
    r.check_count = 3'(p + cfg_secded);
    r.ok          = 1'b1;

    if (act == ActEncode) begin
      for (i = 0; i < p; i++) code[(1 << i) - 1] = calc[i];
      r.overall_parity = ^(code & low);
      if (cfg_secded) code[n] = r.overall_parity;
      r.word_out = code;
    end else begin
      syn = calc ^ stored;
      r.overall_parity = ^(w & low);
      r.word_out = w;
      case (act)
        ActDecode: begin
          r.word_out = '0;
          j = 0;
          for (i = 1; i <= n; i++) begin
            if (!is_check_pos(i)) begin
              r.word_out[j] = w[i-1];
              j++;
            end
          end
          r.ok = (syn == 5'd0);
        end
        ActCorrect: begin
          // A syndrome pointing past the codeword cannot be fixed and the
          // word comes back untouched.
          if (syn != 5'd0) begin
            if (syn <= n) r.word_out[syn-1] = ~w[syn-1];
            else r.ok = 1'b0;
          end
        end
        default: begin
          // The parity check runs whatever the SECDED enable holds.
          r.ok = (r.overall_parity == w[n]);
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic hsc_in_t make_item(hsc_action_e act, logic [31:0] w);
    hsc_in_t it;
    it.action  = act;
    it.word_in = w;
    return it;
  endfunction

  // Unless the idle rate is high, most commands follow each other back to
  // back; of the gaps, most are short and a few are long.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) >= idle_percent) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Random command under the current configuration. Half of them take a
  // real codeword with zero, one or two bits flipped through the checking
  // actions, so the correction and parity paths see meaningful syndromes.
  function automatic hsc_in_t random_item();
    hsc_in_t     it;
    hsc_out_t    enc;
    int unsigned roll, n, flips, f, pos;
    logic [31:0] w;
    n = eff_width() + check_bit_count(eff_width());
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      it = make_item(ActEncode, $urandom);
    end else if (roll < 80) begin
      enc = predict_codec(ActEncode, $urandom);
      w = enc.word_out;
      flips = $urandom_range(0, 2);
      for (f = 0; f < flips; f++) begin
        pos = $urandom_range(0, n);
        w[pos] = ~w[pos];
      end
      // Sometimes junk above the codeword and its parity bit, which the
      // checks must ignore.
      if ($urandom_range(0, 4) == 0) begin
        w |= $urandom & 32'(~((64'd1 << (n + 1)) - 64'd1));
      end
      it = make_item(hsc_action_e'($urandom_range(1, 3)), w);
    end else begin
      it = make_item(hsc_action_e'($urandom_range(0, 3)), $urandom);
    end
    return it;
  endfunction

  // Send one command and wait for its transfer. The start strobe is left
  // high on return so that a following command can go out back to back;
  // it is lowered where a gap begins or when sending stops.
  task automatic send_item(input hsc_in_t it);
    int unsigned gap;
    bit          taken;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    taken = 1'b0;
    // busy_o is sampled mid-cycle, where it holds the value that the
    // coming rising edge will see.
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
    codec_results_due.push_back(predict_codec(it.action, it.word_in));
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic wait_for_results();
    start_i <= 1'b0;
    while (codec_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers while the codec is idle. The unused upper bits of
  // the enable write carry random filler, which the codec must ignore.
  task automatic set_codec_config(input logic [4:0] width, input logic secded);
    logic [3:0] filler;
    filler = 4'($urandom);
    wait_for_results();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgDataBits;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_idx_i   <= CfgSecdedEn;
    cfg_wdata_i <= {filler, secded};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_width  = width;
    cfg_secded = secded;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: four data bits, no SECDED. All-ones data also shows
  // that data bits above the width are dropped on encode.
  task automatic test_power_on_defaults();
    send_item(make_item(ActEncode, 32'h0000_0000));
    send_item(make_item(ActEncode, 32'hFFFF_FFFF));
    send_item(make_item(ActDecode, 32'hFFFF_FFFF));
    send_item(make_item(ActCorrect, 32'h0000_0000));
    send_item(make_item(ActSecdedCheck, 32'hFFFF_FFFF));
  endtask

  // Widest codeword with the overall parity bit in the top bit of the word.
  task automatic test_wide_word_secded();
    logic [31:0] code;
    hsc_out_t    enc;
    set_codec_config(5'd26, 1'b1);
    send_item(make_item(ActEncode, 32'h0000_0000));
    send_item(make_item(ActEncode, 32'hFFFF_FFFF));
    send_item(make_item(ActDecode, 32'h0000_0000));
    send_item(make_item(ActDecode, 32'hFFFF_FFFF));
    send_item(make_item(ActCorrect, 32'hFFFF_FFFF));
    send_item(make_item(ActSecdedCheck, 32'h0000_0000));
    send_item(make_item(ActSecdedCheck, 32'hFFFF_FFFF));
    enc = predict_codec(ActEncode, 32'h02AA_AAAA);
    code = enc.word_out;
    // A single flipped data bit is fixed; a flipped overall parity bit gives
    // a zero syndrome, so the word must come back unchanged.
    send_item(make_item(ActCorrect, code ^ 32'h0010_0000));
    send_item(make_item(ActCorrect, code ^ 32'h8000_0000));
    send_item(make_item(ActSecdedCheck, code ^ 32'h0000_0400));
  endtask

  // Width register values of zero and above the maximum are clamped.
  task automatic test_width_clamping();
    set_codec_config(5'd0, 1'b1);
    send_item(make_item(ActEncode, 32'h0000_0001));
    send_item(make_item(ActCorrect, 32'h0000_0001));
    send_item(make_item(ActSecdedCheck, 32'h0000_0008));
    set_codec_config(5'd31, 1'b0);
    send_item(make_item(ActEncode, 32'h03FF_FFFF));
    send_item(make_item(ActDecode, $urandom));
  endtask

  // With two data bits the codeword has five positions but the syndrome can
  // reach seven. Word 0xC sets data position 3 and check position 4, which
  // gives syndrome 7, past the end of the codeword.
  task automatic test_syndrome_out_of_range();
    set_codec_config(5'd2, 1'b0);
    send_item(make_item(ActCorrect, 32'h0000_000C));
    send_item(make_item(ActCorrect, 32'h0000_0004));
    send_item(make_item(ActDecode, 32'h0000_000C));
  endtask

  // Random commands across many settings, with the idle rate changed from
  // one setting to the next so that some runs go back to back throughout.
  task automatic test_random_settings();
    int unsigned s, i;
    for (s = 0; s < RandomSettings; s++) begin
      if (s < 8) set_codec_config(fixed_settings[s][4:0], fixed_settings[s][5]);
      else set_codec_config(5'($urandom), 1'($urandom));
      case ($urandom_range(0, 2))
        0: idle_percent = 0;
        1: idle_percent = 20;
        default: idle_percent = 60;
      endcase
      for (i = 0; i < ItemsPerSetting; i++) send_item(random_item());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("tb_top: mismatch in %s at %0t: expected %h, got %h",
               field, $realtime, want, got);
    end
  endtask

  // The result strobe lasts one full cycle, so it is sampled on the falling
  // edge, away from the edges where the codec and the driver update.
  always @(negedge clk_i) begin : check_results
    hsc_out_t want;
    if (rst_ni && result_valid_o) begin
      if (codec_results_due.size() == 0) begin
        report_mismatch("unexpected result word", '0, result_o.word_out);
      end else begin
        want = codec_results_due.pop_front();
        if (result_o.word_out !== want.word_out)
          report_mismatch("word_out", want.word_out, result_o.word_out);
        if (result_o.ok !== want.ok)
          report_mismatch("ok", 32'(want.ok), 32'(result_o.ok));
        if (result_o.check_bits !== want.check_bits)
          report_mismatch("check_bits", 32'(want.check_bits), 32'(result_o.check_bits));
        if (result_o.check_count !== want.check_count)
          report_mismatch("check_count", 32'(want.check_count),
                          32'(result_o.check_count));
        if (result_o.overall_parity !== want.overall_parity)
          report_mismatch("overall_parity", 32'(want.overall_parity),
                          32'(result_o.overall_parity));
      end
    end
  end

  // Watchdog: any transfer on the command, result or config port counts as
  // progress. A long stretch without one ends the run as a failure.
  always @(negedge clk_i) begin : watchdog
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgDataBits;
    cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_defaults();
    test_wide_word_secded();
    test_width_clamping();
    test_syndrome_out_of_range();
    test_random_settings();

    // Let the last results drain, then watch for any stray result strobe
    // before the verdict.
    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
